// File: hdl/met_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Mandelbrot escape-time unit.
// Used by the interfaces, the controller, the datapath and the top level.
package met_pkg;

    // Q6.26 signed fixed point
    localparam int FRAC_W  = 26;
    localparam int Q_W     = 32;
    localparam int SPAN_W  = 31;
    localparam int ITER_W  = 16;
    localparam int PROD_W  = 2 * Q_W;
    localparam int WIDE_W  = 48;

    // Image geometry, powers of two so that the span divides by a shift
    localparam int IMAGE_WIDTH  = 256;
    localparam int IMAGE_HEIGHT = 256;
    localparam int ROW_W        = $clog2(IMAGE_WIDTH);
    localparam int COL_W        = $clog2(IMAGE_HEIGHT);
    localparam int STEP_RE_W    = SPAN_W + 1 + ROW_W;
    localparam int STEP_IM_W    = SPAN_W + 1 + COL_W;

    // Bailout radius 4, compared on |z|^2 in Q.52
    localparam int BAILOUT = 4;
    localparam logic [PROD_W-1:0] BAILOUT_SQ =
        PROD_W'(BAILOUT * BAILOUT) << (2 * FRAC_W);

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_RE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IM = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPAN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = CFG_IDX_W'(3);

    localparam logic [SPAN_W-1:0] HALF_SPAN_RST = SPAN_W'(335544);
    localparam logic [ITER_W-1:0] MAX_ITER_RST  = ITER_W'(600);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_MUL,
        S_EVAL,
        S_HOLD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic map;
        logic mul;
        logic step;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cont;
    } status_t;

    // Clamp a wide signed value onto the Q6.26 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[WIDE_W-1:Q_W-1];
        all_zero = ~|v[WIDE_W-1:Q_W-1];
        if (all_one || all_zero)
            return v[Q_W-1:0];
        else if (v[WIDE_W-1])
            return {1'b1, {(Q_W-1){1'b0}}};
        else
            return {1'b0, {(Q_W-1){1'b1}}};
    endfunction

endpackage

// File: hdl/met_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the escape-time unit: pixel requests, results and
// configuration writes. Depends on met_pkg.
interface met_pixel_if;
    import met_pkg::*;
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;

    modport source (output valid, output row, output column, input ready);
    modport sink   (input valid, input row, input column, output ready);
endinterface

interface met_result_if;
    import met_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ITER_W-1:0]     iterations;
    logic                  escaped;
    logic signed [Q_W-1:0] final_re;
    logic signed [Q_W-1:0] final_im;

    modport source (output valid, output iterations, output escaped,
                    output final_re, output final_im, input ready);
    modport sink   (input valid, input iterations, input escaped,
                    input final_re, input final_im, output ready);
endinterface

interface met_cfg_if;
    import met_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/met_datapath.sv
`timescale 1ns / 1ps
// Datapath: pixel mapping, complex square-and-add iteration and result register.
// Driven by met_ctrl through met_pkg::cmd_t; depends on met_pkg.
module met_datapath (
    input  logic                          clk,
    input  met_pkg::cmd_t                 cmd,
    output met_pkg::status_t              status,
    input  logic [met_pkg::ROW_W-1:0]     row,
    input  logic [met_pkg::COL_W-1:0]     column,
    input  logic signed [met_pkg::Q_W-1:0] center_re,
    input  logic signed [met_pkg::Q_W-1:0] center_im,
    input  logic [met_pkg::SPAN_W-1:0]    half_span,
    input  logic [met_pkg::ITER_W-1:0]    max_iter,
    output logic [met_pkg::ITER_W-1:0]    iterations,
    output logic                          escaped,
    output logic signed [met_pkg::Q_W-1:0] final_re,
    output logic signed [met_pkg::Q_W-1:0] final_im
);
    import met_pkg::*;

    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        col_reg;
    logic signed [Q_W-1:0]   cr_reg, cr_next;
    logic signed [Q_W-1:0]   ci_reg, ci_next;
    logic signed [Q_W-1:0]   zr_reg, zr_next;
    logic signed [Q_W-1:0]   zi_reg, zi_next;
    logic [ITER_W-1:0]       count_reg, count_next;
    logic signed [PROD_W-1:0] rr_reg, ii_reg, ri_reg;
    logic [ITER_W-1:0]       iter_out_reg;
    logic                    esc_out_reg;
    logic signed [Q_W-1:0]   fre_out_reg, fim_out_reg;

    logic [STEP_RE_W-1:0]     prod_re;
    logic [STEP_IM_W-1:0]     prod_im;
    logic signed [WIDE_W-1:0] map_re, map_im;
    logic signed [PROD_W-1:0] diff;
    logic signed [WIDE_W-1:0] new_re, new_im;
    logic [PROD_W-1:0]        mag;

    // Coordinate = centre - half span + floor(2 * half span * index / size)
    always_comb
    begin
        prod_re = STEP_RE_W'({half_span, 1'b0}) * STEP_RE_W'(row_reg);
        prod_im = STEP_IM_W'({half_span, 1'b0}) * STEP_IM_W'(col_reg);
        map_re  = WIDE_W'(center_re) - $signed(WIDE_W'(half_span))
                + $signed(WIDE_W'(prod_re >> ROW_W));
        map_im  = WIDE_W'(center_im) - $signed(WIDE_W'(half_span))
                + $signed(WIDE_W'(prod_im >> COL_W));
        cr_next = sat_q(map_re);
        ci_next = sat_q(map_im);
    end

    // Square-and-add on the registered products; arithmetic shift is the floor
    always_comb
    begin
        diff    = rr_reg - ii_reg;
        new_re  = WIDE_W'(diff >>> FRAC_W) + WIDE_W'(cr_reg);
        new_im  = WIDE_W'(ri_reg >>> (FRAC_W - 1)) + WIDE_W'(ci_reg);
        mag     = $unsigned(rr_reg) + $unsigned(ii_reg);
        status.cont = (mag <= BAILOUT_SQ) && (count_reg < max_iter);

        zr_next    = zr_reg;
        zi_next    = zi_reg;
        count_next = count_reg;
        if (cmd.map)
        begin
            zr_next    = '0;
            zi_next    = '0;
            count_next = '0;
        end
        else if (cmd.step)
        begin
            zr_next    = sat_q(new_re);
            zi_next    = sat_q(new_im);
            count_next = count_reg + ITER_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            row_reg <= row;
            col_reg <= column;
        end
        if (cmd.map)
        begin
            cr_reg <= cr_next;
            ci_reg <= ci_next;
        end
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        count_reg <= count_next;
        if (cmd.mul)
        begin
            rr_reg <= zr_reg * zr_reg;
            ii_reg <= zi_reg * zi_reg;
            ri_reg <= zr_reg * zi_reg;
        end
        if (cmd.load_out)
        begin
            iter_out_reg <= count_reg;
            esc_out_reg  <= (count_reg < max_iter);
            fre_out_reg  <= zr_reg;
            fim_out_reg  <= zi_reg;
        end
    end

    assign iterations = iter_out_reg;
    assign escaped    = esc_out_reg;
    assign final_re   = fre_out_reg;
    assign final_im   = fim_out_reg;

endmodule

// File: hdl/met_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences mapping and iteration passes, owns the result valid flag.
// Depends on met_pkg for state_t, cmd_t and status_t.
module met_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  met_pkg::status_t status,
    output met_pkg::cmd_t    cmd
);
    import met_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_MAP;
            S_MAP:
                state_next = S_MUL;
            S_MUL:
                state_next = S_EVAL;
            S_EVAL:
                if (status.cont)
                    state_next = S_MUL;
                else if (slot_free)
                    state_next = S_IDLE;
                else
                    state_next = S_HOLD;
            S_HOLD:
                if (slot_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_MAP:
                cmd.map = 1'b1;
            S_MUL:
                cmd.mul = 1'b1;
            S_EVAL:
            begin
                cmd.step     = status.cont;
                cmd.load_out = !status.cont && slot_free;
            end
            S_HOLD:
                cmd.load_out = slot_free;
            default:
                cmd = '0;
        endcase
    end

    // Hold the result until taken; a new load may replace one taken this cycle
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while one is in flight");

    a_valid_rises_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load_out))
        else $error("result valid without a load");

    a_map_then_multiply: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.map |=> cmd.mul)
        else $error("mapping not followed by a multiply pass");

endmodule

// File: hdl/mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps
// Top level of the Mandelbrot escape-time unit: configuration registers,
// controller and datapath. Depends on met_pkg, met_if, met_ctrl, met_datapath.
//
//  channel  modport  payload                                       accepted when
//  pixel    sink     row, column                                   valid & ready
//  result   source   iterations, escaped, final_re, final_im       valid & ready
//  cfg      sink     index, data (always ready)                    valid & ready
//
// A pixel with n iterations passes through the request state, the mapping state,
// then a multiply pass and an update pass per iteration and a final pair that
// ends the loop; the three registered 32x32 products of z split each iteration.
// rst_n resets the controller and the configuration registers at once.
// A finished result waits in the output register; the next pixel is taken meanwhile
// and, if it finishes first, holds until the register is free.
module mandelbrot_escape_time_unit (
    input  logic clk,
    input  logic rst_n,
    met_pixel_if.sink    pixel,
    met_result_if.source result,
    met_cfg_if.sink      cfg
);
    import met_pkg::*;

    logic signed [Q_W-1:0] center_re_reg;
    logic signed [Q_W-1:0] center_im_reg;
    logic [SPAN_W-1:0]     half_span_reg;
    logic [ITER_W-1:0]     max_iter_reg;
    cmd_t                  cmd;
    status_t               status;

    assign cfg.ready = 1'b1;

    // Drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_re_reg <= '0;
            center_im_reg <= '0;
            half_span_reg <= HALF_SPAN_RST;
            max_iter_reg  <= MAX_ITER_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CENTER_RE: center_re_reg <= $signed(cfg.data[Q_W-1:0]);
                CFG_CENTER_IM: center_im_reg <= $signed(cfg.data[Q_W-1:0]);
                CFG_HALF_SPAN: half_span_reg <= cfg.data[SPAN_W-1:0];
                CFG_MAX_ITER:  max_iter_reg  <= cfg.data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    met_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    met_datapath u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .status     (status),
        .row        (pixel.row),
        .column     (pixel.column),
        .center_re  (center_re_reg),
        .center_im  (center_im_reg),
        .half_span  (half_span_reg),
        .max_iter   (max_iter_reg),
        .iterations (result.iterations),
        .escaped    (result.escaped),
        .final_re   (result.final_re),
        .final_im   (result.final_im)
    );

endmodule

// File: verif/mandelbrot_escape_time_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for mandelbrot_escape_time_unit: drives pixel requests and
// register writes, predicts every escape result in Q6.26 and checks it field by field.
// Depends on met_pkg, the channel interfaces in met_if and the unit itself.
module mandelbrot_escape_time_unit_tb;
    import met_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int LIMIT_NS    = 24_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_REPORTS = 60;
    localparam int RAND_VIEWS  = 10;
    localparam int VIEW_PIXELS = 100;

    localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_HI = {CFG_IDX_W{1'b1}};

    // Q6.26 constants used by the directed views
    localparam logic signed [Q_W-1:0] Q_MINUS_ONE  = 32'shFC00_0000;
    localparam logic signed [Q_W-1:0] Q_MINUS_HALF = 32'shFE00_0000;
    localparam logic signed [Q_W-1:0] Q_MINUS_3_4  = 32'shFD00_0000;
    localparam logic signed [Q_W-1:0] Q_TENTH      = 32'sd6710886;
    localparam logic signed [Q_W-1:0] Q_CUSP_OUT   = 32'sd17448305;
    localparam logic [SPAN_W-1:0]     SPAN_TWO     = 31'h0800_0000;
    localparam logic [SPAN_W-1:0]     SPAN_1_5     = 31'h0600_0000;

    typedef struct {
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      column;
        logic [ITER_W-1:0]     iterations;
        logic                  escaped;
        logic signed [Q_W-1:0] final_re;
        logic signed [Q_W-1:0] final_im;
    } pixel_outcome_t;

    class escape_time_board;
        localparam logic [63:0] ESCAPE_RADIUS_SQ = 64'd1 << 56;

        logic signed [Q_W-1:0] centre_re;
        logic signed [Q_W-1:0] centre_im;
        logic [SPAN_W-1:0]     half_span;
        logic [ITER_W-1:0]     iter_limit;
        pixel_outcome_t        awaited[$];
        int unsigned           failures;
        int unsigned           results_seen;
        int unsigned           escaped_seen;

        function new();
            centre_re  = '0;
            centre_im  = '0;
            half_span  = 31'd335544;
            iter_limit = 16'd600;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_CENTER_RE: centre_re  = value;
                CFG_CENTER_IM: centre_im  = value;
                CFG_HALF_SPAN: half_span  = value[SPAN_W-1:0];
                CFG_MAX_ITER:  iter_limit = value[ITER_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [Q_W-1:0] clamp_q(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'sh8000_0000;
            return v[Q_W-1:0];
        endfunction

        function logic signed [Q_W-1:0] axis_coord(logic signed [Q_W-1:0] centre,
                                                   int unsigned idx, int unsigned size);
            longint step;
            step = (longint'(half_span) * 2 * longint'(idx)) / longint'(size);
            return clamp_q(longint'(centre) - longint'(half_span) + step);
        endfunction

        function void note_pixel(logic [ROW_W-1:0] row, logic [COL_W-1:0] column);
            pixel_outcome_t        o;
            logic signed [Q_W-1:0] cr;
            logic signed [Q_W-1:0] ci;
            logic signed [Q_W-1:0] zr;
            logic signed [Q_W-1:0] zi;
            longint                rr;
            longint                ii;
            longint                ri;
            logic [63:0]           radius_sq;
            int unsigned           count;
            cr    = axis_coord(centre_re, row, IMAGE_WIDTH);
            ci    = axis_coord(centre_im, column, IMAGE_HEIGHT);
            zr    = '0;
            zi    = '0;
            count = 0;
            forever begin
                rr        = longint'(zr) * longint'(zr);
                ii        = longint'(zi) * longint'(zi);
                radius_sq = rr + ii;
                if (radius_sq > ESCAPE_RADIUS_SQ || count >= iter_limit)
                    break;
                ri = longint'(zr) * longint'(zi);
                // floor division by a power of two is an arithmetic shift
                zr = clamp_q(((rr - ii) >>> FRAC_W) + longint'(cr));
                zi = clamp_q((ri >>> (FRAC_W - 1)) + longint'(ci));
                count++;
            end
            o.row        = row;
            o.column     = column;
            o.iterations = count[ITER_W-1:0];
            o.escaped    = (count < iter_limit);
            o.final_re   = zr;
            o.final_im   = zi;
            if (o.escaped)
                escaped_seen++;
            awaited.push_back(o);
        endfunction

        function void compare_field(string label, pixel_outcome_t want,
                                    logic signed [63:0] want_v, logic signed [63:0] got_v);
            if (got_v !== want_v) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: pixel (%0d, %0d) %s expected %0d, actual %0d",
                             $time, want.row, want.column, label, want_v, got_v);
            end
        endfunction

        function void check_result(logic [ITER_W-1:0] iterations, logic escaped,
                                   logic signed [Q_W-1:0] fre, logic signed [Q_W-1:0] fim);
            pixel_outcome_t want;
            results_seen++;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: result with no request outstanding, expected none, actual %0d",
                             $time, iterations);
                return;
            end
            want = awaited.pop_front();
            compare_field("iterations", want, want.iterations, iterations);
            compare_field("escaped",    want, want.escaped,    escaped);
            compare_field("final_re",   want, want.final_re,   fre);
            compare_field("final_im",   want, want.final_im,   fim);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    met_pixel_if  pixel_ch ();
    met_result_if result_ch ();
    met_cfg_if    cfg_ch ();

    mandelbrot_escape_time_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    escape_time_board escape_board = new();
    bit               calm;
    bit               long_hold_req;
    int unsigned      views_used;

    always
    begin
        clk = 1'b0;
        #(CLK_PERIOD / 2);
        clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Result side: check each accepted result, then choose next cycle's ready
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                escape_board.check_result(result_ch.iterations, result_ch.escaped,
                                          result_ch.final_re, result_ch.final_im);
            if (long_hold_req) begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (hold_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(1, 8);
            end
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column);
        if (!calm && $urandom_range(0, 5) == 0) begin
            pixel_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        pixel_ch.valid  <= 1'b1;
        pixel_ch.row    <= row;
        pixel_ch.column <= column;
        do @(posedge clk); while (!pixel_ch.ready);
        escape_board.note_pixel(row, column);
    endtask

    // Drop the request and wait for every outstanding result
    task automatic settle();
        pixel_ch.valid <= 1'b0;
        while (escape_board.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        escape_board.write_register(idx, value);
    endtask

    // Unused upper bits of the narrow registers carry junk that must be dropped
    task automatic write_view(input logic signed [Q_W-1:0] cre, input logic signed [Q_W-1:0] cim,
                              input logic [SPAN_W-1:0] span, input logic [ITER_W-1:0] limit);
        settle();
        write_reg(CFG_CENTER_RE, cre);
        write_reg(CFG_CENTER_IM, cim);
        write_reg(CFG_HALF_SPAN, {1'($urandom), span});
        write_reg(CFG_MAX_ITER, {16'($urandom), limit});
        cfg_ch.valid <= 1'b0;
        views_used++;
    endtask

    initial
    begin
        logic signed [Q_W-1:0] cre;
        logic signed [Q_W-1:0] cim;
        logic [SPAN_W-1:0]     span;
        logic [ITER_W-1:0]     limit;
        int                    ph;
        int                    k;
        rst_n           <= 1'b0;
        pixel_ch.valid  <= 1'b0;
        pixel_ch.row    <= '0;
        pixel_ch.column <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: a tiny window round the origin, every pixel inside
        views_used = 1;
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd128, 8'd128);

        // classic full view, mix of escaping and bounded pixels
        write_view(Q_MINUS_HALF, '0, SPAN_TWO, 16'd64);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'h55, 8'hAA);
        send_pixel(8'hAA, 8'h55);
        send_pixel(8'd128, 8'd128);
        send_pixel(8'd96, 8'd160);

        // coordinates and products saturate at both ends of the range
        write_view(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 16'd3);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd255, 8'd0);

        // zero limit: no iteration at all
        write_view('0, '0, SPAN_TWO, 16'd0);
        send_pixel(8'd17, 8'd200);
        send_pixel(8'd255, 8'd0);

        // zero span at the period-two point: runs the full largest limit
        write_view(Q_MINUS_ONE, '0, '0, 16'hFFFF);
        send_pixel(8'd200, 8'd33);
        // just past the cusp: slow escape under the largest limit
        write_view(Q_CUSP_OUT, '0, '0, 16'hFFFF);
        send_pixel(8'd7, 8'd250);

        // writes to unmapped indexes must leave the view alone
        write_view(Q_MINUS_3_4, Q_TENTH, SPAN_1_5, 16'd40);
        @(posedge clk);
        write_reg(UNMAPPED_IDX_LO, $urandom);
        write_reg(UNMAPPED_IDX_HI, $urandom);
        cfg_ch.valid <= 1'b0;
        send_pixel(8'd64, 8'd128);
        send_pixel(8'd192, 8'd100);
        send_pixel(8'd128, 8'd160);

        for (ph = 0; ph < RAND_VIEWS; ph++) begin
            calm  = (ph >= RAND_VIEWS - 2);
            limit = (ph == 1) ? 16'd4 : 16'($urandom_range(1, 128));
            if (ph == 5 || $urandom_range(0, 3) == 0) begin
                cre  = $urandom;
                cim  = $urandom;
                span = 31'($urandom);
            end else begin
                cre  = $signed($urandom_range(0, 32'h0C00_0000)) - 32'sh0800_0000;
                cim  = $signed($urandom_range(0, 32'h0C00_0000)) - 32'sh0600_0000;
                span = 31'($urandom_range(32'h0004_0000, 32'h0800_0000));
            end
            write_view(cre, cim, span, limit);
            // short limit keeps the unit busy so the input backs up during the hold
            if (ph == 1)
                long_hold_req = 1'b1;
            for (k = 0; k < VIEW_PIXELS; k++) begin
                if (ph == 3 && k == VIEW_PIXELS / 2)
                    settle();
                send_pixel(8'($urandom), 8'($urandom));
            end
        end

        settle();
        repeat (16) @(posedge clk);
        $display("Checked %0d pixel results over %0d views: %0d escaped, the rest hit the limit.",
                 escape_board.results_seen, views_used, escape_board.escaped_seen);
        $display("Views covered saturating corners, zero span, limits 0 to 65535 and unmapped writes.");
        if (escape_board.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
